// ----- rtl/tlps_pkg.sv -----
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types and constants for the two-level preemptive scheduler.
// ----------------------------------------------------------------------------
package tlps_pkg;

    // Request kinds, carried on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam int ITEM_W   = 37;   // packed input fields in s_tdata
    localparam int IN_TDATA_W  = 40;
    localparam int RES_W    = 103;  // packed result fields in m_tdata
    localparam int OUT_TDATA_W = 104;

    // Input word; first declared member sits in the top bits
    typedef struct packed {
        logic        is_user;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [3:0]  slot;
    } item_t;

    // Result word, busy_res in bit 0
    typedef struct packed {
        logic        all_done;
        logic [31:0] waiting;
        logic [31:0] turnaround;
        logic [31:0] completion_time;
        logic        finished;
        logic [3:0]  ran_slot;
        logic        busy_res;
    } res_t;

endpackage

// ----- rtl/tlps_pick.sv -----
// ----------------------------------------------------------------------------
// tlps_pick
// Two-class priority pick: lowest ready system slot, else lowest ready user.
// ----------------------------------------------------------------------------
module tlps_pick
#(
    parameter int SLOTS = 16
)
(
    input  logic [SLOTS-1:0] pending,   // slot still has work
    input  logic [SLOTS-1:0] arrived,   // arrival <= current time
    input  logic [SLOTS-1:0] user_cls,  // 1 = user class
    output logic             hit,
    output logic [SLOTS-1:0] grant      // one-hot, zero when no hit
);

    logic [SLOTS-1:0] sys_rdy;
    logic [SLOTS-1:0] usr_rdy;
    logic [SLOTS-1:0] cand;

    assign sys_rdy = pending & arrived & ~user_cls;
    assign usr_rdy = pending & arrived & user_cls;
    assign cand    = (|sys_rdy) ? sys_rdy : usr_rdy;

    // isolate lowest set bit
    assign grant = cand & (~cand + {{(SLOTS-1){1'b0}}, 1'b1});
    assign hit   = |cand;

endmodule

// ----- rtl/two_level_preemptive_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// two_level_preemptive_scheduler_top
// Task table with a system-over-user preemptive pick, one time tick per tick word.
// ----------------------------------------------------------------------------
// Usage: each accepted input word is either a load (s_tuser = 0), which writes
// one task slot, or a tick (s_tuser = 1), which runs the chosen task for one
// unit and advances the time counter (saturating at 2^32-1). Every input word
// produces exactly one result word. Words pass through an input register and a
// result register; selection, decrement and the time arithmetic sit between
// them, and a new word is taken every cycle while the result side keeps up.
// Throughput is set by the single register-to-register pass over the slot
// table (priority pick over SLOTS slots, one decrement, time subtraction). Loads
// to a slot at or above SLOTS are dropped; a burst of zero leaves the slot idle.
module two_level_preemptive_scheduler_top
    import tlps_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot[3:0], arrival[19:4], burst[35:20], is_user[36], zero pad [39:37]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // busy_res[0], ran_slot[4:1], finished[5], completion_time[37:6],
    // turnaround[69:38], waiting[101:70], all_done[102], zero pad [103]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // ------------------------------------------------------------------
    // Handshake / input stage
    // ------------------------------------------------------------------
    logic  in_valid_reg;
    logic  in_tick_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    res_t  res_reg;
    res_t  res_next;

    logic  out_free;
    logic  advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
            in_tick_reg <= s_tuser;
        end
        if (advance)
            res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // Task table and time
    // ------------------------------------------------------------------
    logic [15:0]      rem_reg   [SLOTS];
    logic [15:0]      arr_reg   [SLOTS];
    logic [15:0]      burst_reg [SLOTS];
    logic [SLOTS-1:0] cls_reg;
    logic [31:0]      now_reg;

    logic [15:0]      rem_next [SLOTS];
    logic [31:0]      now_next;

    logic [SLOTS-1:0] pending;
    logic [SLOTS-1:0] arrived;
    logic [SLOTS-1:0] load_hit;
    logic             pick_hit;
    logic [SLOTS-1:0] grant;

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            pending[s]  = rem_reg[s] != 16'd0;
            arrived[s]  = (|now_reg[31:16]) || (arr_reg[s] <= now_reg[15:0]);
            load_hit[s] = (in_tick_reg == REQ_LOAD) &&
                          (32'(s) == {28'd0, in_item_reg.slot});
        end
    end

    tlps_pick #(
        .SLOTS    (SLOTS)
    ) u_pick (
        .pending  (pending),
        .arrived  (arrived),
        .user_cls (cls_reg),
        .hit      (pick_hit),
        .grant    (grant)
    );

    // ------------------------------------------------------------------
    // Result and next state
    // ------------------------------------------------------------------
    logic             tick;
    logic             run;
    logic             done;
    logic [15:0]      sel_rem;
    logic [15:0]      sel_arr;
    logic [15:0]      sel_burst;
    logic [3:0]       sel_idx;
    logic [31:0]      tat;
    logic [31:0]      wt;
    logic [SLOTS-1:0] pend_after;

    always_comb
    begin
        tick      = in_tick_reg == REQ_TICK;
        run       = tick && pick_hit;
        sel_rem   = '0;
        sel_arr   = '0;
        sel_burst = '0;
        sel_idx   = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (grant[s])
            begin
                sel_rem   = sel_rem   | rem_reg[s];
                sel_arr   = sel_arr   | arr_reg[s];
                sel_burst = sel_burst | burst_reg[s];
                sel_idx   = sel_idx   | 4'(s);
            end
        end
        done = run && (sel_rem == 16'd1);

        if (tick && (now_reg != TIME_MAX))
            now_next = now_reg + 32'd1;
        else
            now_next = now_reg;

        tat = now_next - {16'd0, sel_arr};
        wt  = (tat >= {16'd0, sel_burst}) ? (tat - {16'd0, sel_burst}) : 32'd0;

        for (int s = 0; s < SLOTS; s++)
        begin
            if (load_hit[s])
                rem_next[s] = in_item_reg.burst;
            else if (run && grant[s])
                rem_next[s] = rem_reg[s] - 16'd1;
            else
                rem_next[s] = rem_reg[s];
            pend_after[s] = rem_next[s] != 16'd0;
        end

        res_next.busy_res        = run;
        res_next.ran_slot        = run ? sel_idx : 4'd0;
        res_next.finished        = done;
        res_next.completion_time = done ? now_next : 32'd0;
        res_next.turnaround      = done ? tat : 32'd0;
        res_next.waiting         = done ? wt : 32'd0;
        res_next.all_done        = ~|pend_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            for (int s = 0; s < SLOTS; s++)
                rem_reg[s] <= '0;
        end
        else if (advance)
        begin
            now_reg <= now_next;
            for (int s = 0; s < SLOTS; s++)
                rem_reg[s] <= rem_next[s];
        end
    end

    // arrival, burst and class only matter once a slot holds work
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            if (advance && load_hit[s])
            begin
                arr_reg[s]   <= in_item_reg.arrival;
                burst_reg[s] <= in_item_reg.burst;
                cls_reg[s]   <= in_item_reg.is_user;
            end
        end
    end

`ifndef SYNTHESIS
    a_grant_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant))
        else $error("pick grant not one-hot");

    a_time_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> now_reg >= $past(now_reg))
        else $error("time counter went backwards");

    a_finish_runs : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.finished |->
            res_reg.busy_res && (res_reg.turnaround <= res_reg.completion_time))
        else $error("completion without a run or bad turnaround");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule
